### design/lprt_pkg.sv
// Shared types, constants and helpers of the route table.
package lprt_pkg;

  localparam int unsigned DEFAULT_DEPTH = 32;
  localparam logic [5:0]  FULL_PREFIX   = 6'd32;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_GET    = 2'd3
  } req_t;

  typedef struct packed {
    logic [31:0] dest;
    logic [5:0]  prefix;
    logic [31:0] gateway;
    logic [7:0]  port;
    logic [31:0] cost;
  } entry_t;

  // Network mask for a prefix length; lengths of 32 and up give all ones.
  function automatic logic [31:0] mask_of(input logic [5:0] plen);
    logic [31:0] m;
    if (plen >= FULL_PREFIX) begin
      m = 32'hFFFF_FFFF;
    end else begin
      m = ~(32'hFFFF_FFFF >> plen);
    end
    return m;
  endfunction

endpackage

### design/lprt_store.sv
// Entry memory: one write port, one read port with registered read data.
module lprt_store #(
  parameter int unsigned DEPTH = lprt_pkg::DEFAULT_DEPTH,
  parameter int unsigned IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [IW-1:0]   wr_addr,
  input  lprt_pkg::entry_t wr_data,
  input  logic [IW-1:0]   rd_addr,
  output lprt_pkg::entry_t rd_data
);

  lprt_pkg::entry_t mem [DEPTH];

  // Write and read the entry array.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### design/longest_prefix_route_table.sv
// Top level of the ordered IPv4 route table with longest-prefix lookup.
//
//   channel | handshake           | payload
//   --------+---------------------+-------------------------------------------
//   in      | in_valid / in_stall | req_type ip_address prefix_len next_hop
//           |                     | port_number route_cost entry_index
//   out     | out_valid/out_stall | status out_destination out_prefix_len
//           |                     | out_next_hop out_port_number out_route_cost
//           |                     | entry_total
//
// One request at a time. Lookup, add and remove walk the entry memory one
// entry a cycle through its single read port. Remove then moves each later
// entry down one slot, one per cycle. Get reads just the indexed entry.
// Reset (rst, synchronous) empties the table; no clearing pass is needed.
// A stalled result holds in the output register; the next request is taken
// once the current one is done.
module longest_prefix_route_table #(
  parameter int unsigned TABLE_DEPTH = lprt_pkg::DEFAULT_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [31:0] ip_address,
  input  logic [5:0]  prefix_len,
  input  logic [31:0] next_hop,
  input  logic [7:0]  port_number,
  input  logic [31:0] route_cost,
  input  logic [7:0]  entry_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        status,
  output logic [31:0] out_destination,
  output logic [5:0]  out_prefix_len,
  output logic [31:0] out_next_hop,
  output logic [7:0]  out_port_number,
  output logic [31:0] out_route_cost,
  output logic [5:0]  entry_total
);

  localparam int unsigned IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CMPW = (CW > 8) ? CW : 8;
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_GET,
    S_FINISH
  } state_t;

  state_t            state;
  lprt_pkg::req_t    req;
  logic [31:0]       addr;
  logic [5:0]        plen;
  logic [31:0]       gw;
  logic [7:0]        port;
  logic [31:0]       cost;
  logic [CW-1:0]     count;
  logic [CW-1:0]     ptr;
  logic              pend;
  logic [CW-1:0]     pend_idx;
  logic              have;
  logic              fail;
  lprt_pkg::entry_t  best;

  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  lprt_pkg::entry_t  wr_data;
  logic [IW-1:0]     rd_addr;
  lprt_pkg::entry_t  rd_data;

  logic              accept;
  logic              issue;
  logic              exact;
  logic              covers;
  logic              better;
  logic              walk_end;
  logic              out_free;
  logic [31:0]       in_mask;
  logic [31:0]       ent_mask;

  lprt_store #(
    .DEPTH (TABLE_DEPTH),
    .IW    (IW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign in_mask  = lprt_pkg::mask_of(prefix_len);
  assign ent_mask = lprt_pkg::mask_of(rd_data.prefix);

  // Compare the entry returned by the memory against the request.
  assign exact  = (rd_data.dest == addr) && (rd_data.prefix == plen) &&
                  (rd_data.gateway == gw) && (rd_data.port == port);
  assign covers = ((addr & ent_mask) == (rd_data.dest & ent_mask));
  assign better = !have || (rd_data.prefix > best.prefix) ||
                  ((rd_data.prefix == best.prefix) && (rd_data.cost < best.cost));
  assign issue    = (ptr < count);
  assign walk_end = !pend && !issue;

  // Drive the memory ports from the walk state.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pend_idx[IW-1:0];
    wr_data = rd_data;
    rd_addr = ptr[IW-1:0];
    unique case (state)
      S_IDLE: begin
        rd_addr = IW'(entry_index);
      end
      S_SCAN: begin
        if (pend && (req == lprt_pkg::REQ_ADD) && exact) begin
          wr_en        = 1'b1;
          wr_data.cost = cost;
        end else if (walk_end && (req == lprt_pkg::REQ_ADD)) begin
          wr_en   = 1'b1;
          wr_addr = count[IW-1:0];
          wr_data = '{dest: addr, prefix: plen, gateway: gw, port: port, cost: cost};
        end
      end
      S_SHIFT: begin
        if (pend) begin
          wr_en   = 1'b1;
          wr_addr = IW'(pend_idx - CW'(1));
        end
      end
      S_GET, S_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  // Hold state, walk pointers, table count and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      ptr       <= '0;
      pend      <= 1'b0;
      have      <= 1'b0;
      fail      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Raise the result when it drops in, clear it once transferred.
      if ((state == S_FINISH) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            req  <= lprt_pkg::req_t'(req_type);
            addr <= (req_type == lprt_pkg::REQ_LOOKUP) ? ip_address : (ip_address & in_mask);
            plen <= prefix_len;
            gw   <= next_hop;
            port <= port_number;
            cost <= route_cost;
            ptr  <= '0;
            pend <= 1'b0;
            have <= 1'b0;
            fail <= 1'b1;
            unique case (lprt_pkg::req_t'(req_type))
              lprt_pkg::REQ_ADD: begin
                state <= ((prefix_len > lprt_pkg::FULL_PREFIX) || (count == FULL_COUNT))
                         ? S_FINISH : S_SCAN;
              end
              lprt_pkg::REQ_REMOVE: begin
                state <= (prefix_len > lprt_pkg::FULL_PREFIX) ? S_FINISH : S_SCAN;
              end
              lprt_pkg::REQ_LOOKUP: begin
                state <= S_SCAN;
              end
              lprt_pkg::REQ_GET: begin
                state <= (CMPW'(entry_index) < CMPW'(count)) ? S_GET : S_FINISH;
              end
              default: begin
                state <= S_FINISH;
              end
            endcase
          end
        end
        S_SCAN: begin
          // Issue the next read and judge the entry that came back.
          pend_idx <= ptr;
          if (pend && (req == lprt_pkg::REQ_REMOVE) && exact) begin
            ptr   <= pend_idx + CW'(1);
            pend  <= 1'b0;
            state <= S_SHIFT;
          end else begin
            pend <= issue;
            if (issue) begin
              ptr <= ptr + CW'(1);
            end
            if (pend && (req == lprt_pkg::REQ_ADD) && exact) begin
              fail  <= 1'b0;
              state <= S_FINISH;
            end else begin
              if (pend && (req == lprt_pkg::REQ_LOOKUP) && covers && better) begin
                best <= rd_data;
                have <= 1'b1;
              end
              if (walk_end) begin
                if (req == lprt_pkg::REQ_ADD) begin
                  count <= count + CW'(1);
                  fail  <= 1'b0;
                end else if (req == lprt_pkg::REQ_LOOKUP) begin
                  fail <= !have;
                end
                state <= S_FINISH;
              end
            end
          end
        end
        S_SHIFT: begin
          // Move each later entry down one slot.
          pend     <= issue;
          pend_idx <= ptr;
          if (issue) begin
            ptr <= ptr + CW'(1);
          end
          if (walk_end) begin
            count <= count - CW'(1);
            fail  <= 1'b0;
            state <= S_FINISH;
          end
        end
        S_GET: begin
          best  <= rd_data;
          have  <= 1'b1;
          fail  <= 1'b0;
          state <= S_FINISH;
        end
        S_FINISH: begin
          // Drop the result into the output register once it is free.
          if (out_free) begin
            status          <= fail;
            out_destination <= have ? best.dest    : '0;
            out_prefix_len  <= have ? best.prefix  : '0;
            out_next_hop    <= have ? best.gateway : '0;
            out_port_number <= have ? best.port    : '0;
            out_route_cost  <= have ? best.cost    : '0;
            entry_total     <= 6'(count);
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
